### rtl/core/mfc_pkg.sv
package mfc_pkg;

  localparam int unsigned FootCount     = 5;
  localparam int unsigned FootBits      = 5;
  localparam int unsigned PotW          = 10;
  localparam int unsigned TimeW         = 32;
  localparam int unsigned NumW          = 7;
  localparam int unsigned LevelW        = 7;
  localparam int unsigned ChanW         = 5;
  localparam int unsigned LongPressW    = 16;
  localparam int unsigned BankW         = 3;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 16;

  localparam logic [LongPressW-1:0] LongPressReset = LongPressW'(1000);
  localparam logic [ChanW-1:0]      ChannelReset   = ChanW'(1);
  localparam logic [LevelW-1:0]     LevelOn        = LevelW'(127);
  localparam logic [LevelW-1:0]     LevelOff       = LevelW'(0);
  localparam logic [NumW-1:0]       PotController  = NumW'(7);
  localparam logic [NumW-1:0]       BankStep       = NumW'(5);

  typedef enum logic [CfgIdxW-1:0] {
    CfgLongPress = 2'd0,
    CfgChannel   = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    KindControl = 1'b0,
    KindProgram = 1'b1
  } msg_kind_e;

  typedef struct packed {
    msg_kind_e          kind;
    logic [NumW-1:0]    number;
    logic [LevelW-1:0]  level;
  } msg_t;

endpackage

### rtl/core/midi_footswitch_controller_unit.sv
// channel  direction  handshake                 beat payload
// in       sink       in_valid_i / in_stall_o   switch levels, pot sample, time
// out      source     out_valid_o / out_stall_i one message, last flag
// cfg      sink       cfg_valid_i / cfg_ready_o register index, write data
//
// a scan is computed combinationally and its messages land in a batch register
// the batch drains one message a cycle while out_stall_i is low
// the next scan is taken in the cycle the last message of the batch leaves
// a scan that makes no message leaves the batch empty
// reset clears mode, bank, switch tracking, pot value and the batch pending flags
module midi_footswitch_controller_unit #(
  parameter int unsigned FOOT_COUNT = mfc_pkg::FootCount
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_switch_level_i,
  input  logic                              bank_switch_level_i,
  input  logic [mfc_pkg::FootBits-1:0]      foot_levels_i,
  input  logic [mfc_pkg::PotW-1:0]          pot_sample_i,
  input  logic [mfc_pkg::TimeW-1:0]         now_ms_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              message_kind_o,
  output logic [mfc_pkg::NumW-1:0]          number_o,
  output logic [mfc_pkg::LevelW-1:0]        level_o,
  output logic [mfc_pkg::ChanW-1:0]         channel_o,
  output logic                              last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mfc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [mfc_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int unsigned NFeet = (FOOT_COUNT > mfc_pkg::FootBits) ? mfc_pkg::FootBits
                                                                    : FOOT_COUNT;
  localparam int unsigned NSlot = NFeet + 1;

  logic [mfc_pkg::LongPressW-1:0] long_press_q;
  logic [mfc_pkg::ChanW-1:0]      channel_q;

  logic                        program_q, program_d;
  logic                        latching_q, latching_d;
  logic [mfc_pkg::BankW-1:0]   bank_q, bank_d;
  logic                        mode_held_q, mode_held_d;
  logic [mfc_pkg::TimeW-1:0]   press_start_q, press_start_d;
  logic                        bank_held_q, bank_held_d;
  logic [NFeet-1:0]            foot_held_q, foot_held_d;
  logic [NFeet-1:0]            foot_on_q, foot_on_d;
  logic [mfc_pkg::NumW-1:0]    last_pot_q, last_pot_d;

  mfc_pkg::msg_t               batch_q [NSlot];
  mfc_pkg::msg_t               batch_d [NSlot];
  logic [NSlot-1:0]            pend_q, pend_d, new_pend, sel;

  logic                        in_beat, out_beat, drain_last;
  logic [mfc_pkg::TimeW-1:0]   dur;
  logic [mfc_pkg::NumW-1:0]    base, pot7;
  mfc_pkg::msg_t               out_msg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= mfc_pkg::LongPressReset;
      channel_q    <= mfc_pkg::ChannelReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mfc_pkg::CfgLongPress: long_press_q <= cfg_data_i;
        mfc_pkg::CfgChannel:   channel_q    <= cfg_data_i[mfc_pkg::ChanW-1:0];
        default: ;
      endcase
    end
  end

  // lowest pending slot goes out first
  assign sel        = pend_q & (~pend_q + NSlot'(1));
  assign out_valid_o = |pend_q;
  assign out_beat   = out_valid_o && !out_stall_i;
  assign drain_last = out_beat && (pend_q == sel);
  assign in_stall_o = out_valid_o && !drain_last;
  assign in_beat    = in_valid_i && !in_stall_o;

  always_comb begin
    out_msg = '0;
    for (int s = 0; s < NSlot; s++) begin
      if (sel[s]) out_msg = out_msg | batch_q[s];
    end
  end

  assign message_kind_o = out_msg.kind;
  assign number_o       = out_msg.number;
  assign level_o        = out_msg.level;
  assign channel_o      = channel_q;
  assign last_o         = (pend_q == sel);

  assign dur  = now_ms_i - press_start_q;
  assign pot7 = pot_sample_i[mfc_pkg::PotW-1 -: mfc_pkg::NumW];

  always_comb begin
    program_d     = program_q;
    latching_d    = latching_q;
    mode_held_d   = mode_held_q;
    press_start_d = press_start_q;
    bank_d        = bank_q;
    bank_held_d   = bank_held_q;
    foot_held_d   = foot_held_q;
    foot_on_d     = foot_on_q;
    last_pot_d    = last_pot_q;
    new_pend      = '0;
    for (int s = 0; s < NSlot; s++) batch_d[s] = batch_q[s];

    // mode switch
    if (!mode_switch_level_i && !mode_held_q) begin
      press_start_d = now_ms_i;
      mode_held_d   = 1'b1;
    end else if (mode_switch_level_i && mode_held_q) begin
      if (dur < {{(mfc_pkg::TimeW-mfc_pkg::LongPressW){1'b0}}, long_press_q}) begin
        program_d = !program_q;
      end else begin
        latching_d = !latching_q;
      end
      mode_held_d = 1'b0;
    end

    // bank switch
    if (!bank_switch_level_i && !bank_held_q) begin
      bank_d      = bank_q + mfc_pkg::BankW'(1);
      bank_held_d = 1'b1;
    end else if (bank_switch_level_i) begin
      bank_held_d = 1'b0;
    end

    // base is five times (bank index plus one)
    base = {{(mfc_pkg::NumW-mfc_pkg::BankW-2){1'b0}}, bank_d, 2'b00}
         + {{(mfc_pkg::NumW-mfc_pkg::BankW){1'b0}}, bank_d} + mfc_pkg::BankStep;

    for (int i = 0; i < NFeet; i++) begin
      batch_d[i].kind   = mfc_pkg::KindControl;
      batch_d[i].number = mfc_pkg::NumW'(i + 1) + base;
      batch_d[i].level  = mfc_pkg::LevelOff;
      if (!program_d) begin
        if (!foot_levels_i[i] && !foot_held_q[i]) begin
          if (!foot_on_q[i]) begin
            new_pend[i]      = 1'b1;
            batch_d[i].level = mfc_pkg::LevelOn;
            foot_on_d[i]     = 1'b1;
          end else if (latching_d) begin
            new_pend[i]  = 1'b1;
            foot_on_d[i] = 1'b0;
          end
          foot_held_d[i] = 1'b1;
        end else if (foot_levels_i[i]) begin
          if (!latching_d && foot_on_q[i]) begin
            new_pend[i]  = 1'b1;
            foot_on_d[i] = 1'b0;
          end
          foot_held_d[i] = 1'b0;
        end
      end else begin
        batch_d[i].kind   = mfc_pkg::KindProgram;
        batch_d[i].number = mfc_pkg::NumW'(i);
        if (!foot_levels_i[i] && !foot_held_q[i]) begin
          new_pend[i]    = 1'b1;
          foot_held_d[i] = 1'b1;
        end else if (foot_levels_i[i]) begin
          foot_held_d[i] = 1'b0;
        end
      end
    end

    // potentiometer
    batch_d[NFeet].kind   = mfc_pkg::KindControl;
    batch_d[NFeet].number = mfc_pkg::PotController;
    batch_d[NFeet].level  = pot7;
    if (pot7 != last_pot_q) begin
      new_pend[NFeet] = 1'b1;
      last_pot_d      = pot7;
    end

    if (in_beat) begin
      pend_d = new_pend;
    end else if (out_beat) begin
      pend_d = pend_q & ~sel;
    end else begin
      pend_d = pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      program_q     <= 1'b0;
      latching_q    <= 1'b0;
      bank_q        <= '0;
      mode_held_q   <= 1'b0;
      press_start_q <= '0;
      bank_held_q   <= 1'b0;
      foot_held_q   <= '0;
      foot_on_q     <= '0;
      last_pot_q    <= '0;
      pend_q        <= '0;
    end else begin
      pend_q <= pend_d;
      if (in_beat) begin
        program_q     <= program_d;
        latching_q    <= latching_d;
        bank_q        <= bank_d;
        mode_held_q   <= mode_held_d;
        press_start_q <= press_start_d;
        bank_held_q   <= bank_held_d;
        foot_held_q   <= foot_held_d;
        foot_on_q     <= foot_on_d;
        last_pot_q    <= last_pot_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      for (int s = 0; s < NSlot; s++) batch_q[s] <= batch_d[s];
    end
  end

  a_stall_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(pend_q) > 1) |-> in_stall_o)
    else $error("scan taken while batch still holds several messages");

  a_last_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && last_o) |=> (!out_valid_o || $past(in_beat)))
    else $error("messages left after last beat");

  a_program_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && message_kind_o) |-> (level_o == mfc_pkg::LevelOff))
    else $error("program change with nonzero level");

  a_pend_on_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && (pot7 != last_pot_q)) |=> out_valid_o)
    else $error("pot change produced no message");

endmodule
